/* hw/rtl/mtn_pkg.sv */
// Shared types and codes for the Manhattan nearest-neighbor block.
package mtn_pkg;
    localparam logic ACT_ADD   = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    localparam logic [1:0] ST_ADDED    = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;
    localparam logic [1:0] ST_NEIGHBOR = 2'd3;

    localparam int COORD_BITS = 8;
    localparam int DIST_BITS  = 9;

    typedef struct packed {
        logic                         action;
        logic signed [COORD_BITS-1:0] pos_x;
        logic signed [COORD_BITS-1:0] pos_y;
        logic [15:0]                  entry_id;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] found_id;
        logic [8:0]  distance;
        logic [1:0]  rank;
        logic        last;
    } t_out_item;
endpackage

/* hw/rtl/manhattan_top3_nearest.sv */
// Top level: nearest-neighbor search by Manhattan distance over a point table.
// Add: the command is stored in the front queue, then in the output register; adds
//   sustain one per cycle unless the output stalls. Query over N stored points with
//   R results: the scan reads one table entry per cycle, then the results follow one
//   per cycle unless the output stalls; no new command is taken until they are done.
// Reset (synchronous, active low) empties the table, the command queue and the output
//   register; table contents stay undefined and are never read past the fill count.
module manhattan_top3_nearest #(
    parameter int TABLE_DEPTH = 16,
    parameter int NEIGHBORS   = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mtn_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mtn_pkg::t_out_item o_data
);
    logic              cmd_valid, cmd_take;
    mtn_pkg::t_in_item cmd;

    // front: accepts transactions into a short command queue
    mtn_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_item(i_data),
        .o_cmd_valid(cmd_valid), .i_cmd_take(cmd_take), .o_cmd(cmd)
    );

    // back: table update, scan and result emission
    mtn_back #(
        .TABLE_DEPTH(TABLE_DEPTH), .NEIGHBORS(NEIGHBORS)
    ) u_back (
        .i_clk, .i_rst_n, .i_cmd_valid(cmd_valid), .o_cmd_take(cmd_take),
        .i_cmd(cmd), .o_valid, .i_ready, .o_item(o_data)
    );
endmodule

/* hw/rtl/mtn_front.sv */
// Front end: two-entry command queue ahead of the back end.
module mtn_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  mtn_pkg::t_in_item i_item,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take,
    output mtn_pkg::t_in_item o_cmd
);
    mtn_pkg::t_in_item r_q [2];
    logic              r_rd;
    logic              r_wr;
    logic [1:0]        r_cnt;

    logic push, pop;
    assign o_ready     = (r_cnt != 2'd2);
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_take && (r_cnt != 2'd0);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd  <= 1'b0;
            r_wr  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wr] <= i_item;
                r_wr      <= ~r_wr;
            end
            if (pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt != 2'd3) else $error("queue count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2) |-> !push) else $error("push into full queue");
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> o_cmd_valid) else $error("pop from empty queue");
endmodule

/* hw/rtl/mtn_back.sv */
// Back end: point table, one-point-per-cycle scan, sorted best list, result emit.
module mtn_back #(
    parameter int TABLE_DEPTH = 16,
    parameter int NEIGHBORS   = 3
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    output logic               o_cmd_take,
    input  mtn_pkg::t_in_item  i_cmd,
    output logic               o_valid,
    input  logic               i_ready,
    output mtn_pkg::t_out_item o_item
);
    localparam int COORD_BITS = mtn_pkg::COORD_BITS;
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int NW = (NEIGHBORS > 1) ? $clog2(NEIGHBORS) : 1;
    localparam int NCW = $clog2(NEIGHBORS + 1);
    localparam int DW = COORD_BITS + 1;

    typedef enum logic [2:0] {S_IDLE, S_READ, S_SCAN, S_EMIT, S_ONE} t_state;

    logic [15:0]                 r_mem_id [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] r_mem_x [TABLE_DEPTH];
    logic signed [COORD_BITS-1:0] r_mem_y [TABLE_DEPTH];

    t_state                       r_state;
    logic [CW-1:0]                r_count;
    logic [CW-1:0]                r_idx;
    logic signed [COORD_BITS-1:0] r_qx, r_qy;
    logic [15:0]                  r_rid;
    logic signed [COORD_BITS-1:0] r_rx, r_ry;
    logic                         r_rv;
    logic [DW-1:0]                r_bd  [NEIGHBORS];
    logic [15:0]                  r_bid [NEIGHBORS];
    logic [NCW-1:0]               r_nb;
    logic [NCW-1:0]               r_emit;
    logic                         r_valid;
    mtn_pkg::t_out_item           r_item;

    logic signed [COORD_BITS:0] dx, dy;
    logic [COORD_BITS:0]        adx, ady;
    logic [DW-1:0]              d;
    logic [NEIGHBORS-1:0]       beats;
    logic                       out_free;
    logic                       load_out;

    assign out_free = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_item   = r_item;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && out_free;
    // output register reloads this cycle
    assign load_out = (o_cmd_take && ((i_cmd.action == mtn_pkg::ACT_ADD) ||
                                      (r_count == '0))) ||
                      ((r_state == S_EMIT) && out_free);

    always_comb begin
        dx  = {r_qx[COORD_BITS-1], r_qx} - {r_rx[COORD_BITS-1], r_rx};
        dy  = {r_qy[COORD_BITS-1], r_qy} - {r_ry[COORD_BITS-1], r_ry};
        adx = dx[COORD_BITS] ? (COORD_BITS+1)'(-dx) : dx;
        ady = dy[COORD_BITS] ? (COORD_BITS+1)'(-dy) : dy;
        d   = DW'(adx + ady);
        for (int k = 0; k < NEIGHBORS; k++) begin
            beats[k] = (NCW'(k) >= r_nb) || (d < r_bd[k]) ||
                       ((d == r_bd[k]) && (r_rid < r_bid[k]));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
            r_rv    <= 1'b0;
            r_nb    <= '0;
        end else begin
            if (r_valid && i_ready && !load_out) r_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        if (i_cmd.action == mtn_pkg::ACT_ADD) begin
                            r_valid <= 1'b1;
                            if (r_count >= CW'(TABLE_DEPTH)) begin
                                r_item <= '{status: mtn_pkg::ST_FULL, found_id: '0,
                                            distance: '0, rank: '0, last: 1'b1};
                            end else begin
                                r_item <= '{status: mtn_pkg::ST_ADDED, found_id: '0,
                                            distance: '0, rank: '0, last: 1'b1};
                                r_mem_id[r_count[AW-1:0]] <= i_cmd.entry_id;
                                r_mem_x[r_count[AW-1:0]]  <= i_cmd.pos_x[COORD_BITS-1:0];
                                r_mem_y[r_count[AW-1:0]]  <= i_cmd.pos_y[COORD_BITS-1:0];
                                r_count <= r_count + 1'b1;
                            end
                        end else if (r_count == '0) begin
                            r_valid <= 1'b1;
                            r_item  <= '{status: mtn_pkg::ST_EMPTY, found_id: '0,
                                         distance: '0, rank: '0, last: 1'b1};
                        end else begin
                            r_qx    <= i_cmd.pos_x[COORD_BITS-1:0];
                            r_qy    <= i_cmd.pos_y[COORD_BITS-1:0];
                            r_idx   <= '0;
                            r_nb    <= '0;
                            r_rv    <= 1'b0;
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // pipeline: read entry r_idx, insert previously read entry
                    if (r_rv) begin
                        for (int k = NEIGHBORS - 1; k >= 0; k--) begin
                            if (beats[k]) begin
                                if (k == 0 || !beats[(k > 0) ? k - 1 : 0]) begin
                                    r_bd[k]  <= d;
                                    r_bid[k] <= r_rid;
                                end else begin
                                    r_bd[k]  <= r_bd[(k > 0) ? k - 1 : 0];
                                    r_bid[k] <= r_bid[(k > 0) ? k - 1 : 0];
                                end
                            end
                        end
                        if (r_nb < NCW'(NEIGHBORS)) r_nb <= r_nb + 1'b1;
                    end
                    if (r_idx < r_count) begin
                        r_rid <= r_mem_id[r_idx[AW-1:0]];
                        r_rx  <= r_mem_x[r_idx[AW-1:0]];
                        r_ry  <= r_mem_y[r_idx[AW-1:0]];
                        r_rv  <= 1'b1;
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_rv    <= 1'b0;
                        r_emit  <= '0;
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        r_valid <= 1'b1;
                        r_item  <= '{status: mtn_pkg::ST_NEIGHBOR,
                                     found_id: r_bid[r_emit[NW-1:0]],
                                     distance: mtn_pkg::DIST_BITS'(r_bd[r_emit[NW-1:0]]),
                                     rank: 2'(r_emit),
                                     last: (r_emit + 1'b1 == r_nb)};
                        r_emit  <= r_emit + 1'b1;
                        if (r_emit + 1'b1 == r_nb) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_DEPTH)) else $error("point count beyond depth");
    a_nb_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_nb <= NCW'(NEIGHBORS)) else $error("best list overfilled");
    a_emit_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_nb != '0)) else $error("emit with empty list");
endmodule
